[hdl/ebp_pkg.sv]
`timescale 1ns / 1ps

package ebp_pkg;

  typedef enum logic [2:0] {
    OP_RAW    = 3'd0,
    OP_BYTE   = 3'd1,
    OP_GAMMA  = 3'd2,
    OP_HYBRID = 3'd3,
    OP_HUFF   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT
  } state_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ERROR,
    KIND_BYTE,
    KIND_BITS
  } kind_t;

  localparam int unsigned MAX_FIXED_BITS = 32;
  localparam int unsigned GAMMA_LIMIT    = 256;
  localparam int unsigned MAX_OUT        = 6;
  localparam logic [2:0]  BIT_LAST       = 3'h7;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  zeros;
    logic [8:0]  g;
    logic [3:0]  g_len;
    logic [31:0] v;
    logic [5:0]  v_len;
  } plan_t;

  function automatic logic [4:0] msb_width(input logic [15:0] x);
    logic [4:0] w;
    w = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        w = 5'(i + 1);
      end
    end
    return w;
  endfunction

endpackage

[hdl/ebp_decode.sv]
`timescale 1ns / 1ps

module ebp_decode import ebp_pkg::*; (
  input  logic [2:0]  opcode,
  input  logic [31:0] value,
  input  logic [5:0]  bit_count,
  input  logic [15:0] code_word,
  output plan_t       plan
);

  logic [31:0] shifted;
  logic [8:0]  g_src;
  logic [4:0]  g_w;
  logic [4:0]  h_w;

  always_comb begin
    shifted = value >> bit_count;
    if (op_t'(opcode) == OP_HYBRID) begin
      g_src = {1'b0, shifted[7:0]} + 9'd1;
    end else begin
      g_src = value[8:0];
    end
    g_w = msb_width({7'b0, g_src});
    h_w = msb_width(code_word);

    plan.kind  = KIND_ERROR;
    plan.zeros = 4'(g_w - 5'd1);
    plan.g     = g_src;
    plan.g_len = g_w[3:0];
    plan.v     = value;
    plan.v_len = bit_count;

    unique case (op_t'(opcode))
      OP_RAW: begin
        plan.zeros = '0;
        plan.g_len = '0;
        if (bit_count > 6'd32) begin
          plan.kind = KIND_ERROR;
        end else if (bit_count == 6'd0) begin
          plan.kind = KIND_NONE;
        end else begin
          plan.kind = KIND_BITS;
        end
      end
      OP_BYTE: begin
        plan.kind = KIND_BYTE;
      end
      OP_GAMMA: begin
        plan.v_len = '0;
        if (value == 32'd0 || value > 32'(GAMMA_LIMIT)) begin
          plan.kind = KIND_ERROR;
        end else begin
          plan.kind = KIND_BITS;
        end
      end
      OP_HYBRID: begin
        if (bit_count > 6'(MAX_FIXED_BITS) || shifted[31:8] != 24'd0) begin
          plan.kind = KIND_ERROR;
        end else begin
          plan.kind = KIND_BITS;
        end
      end
      OP_HUFF: begin
        plan.zeros = '0;
        plan.g_len = '0;
        plan.v     = {16'd0, code_word};
        plan.v_len = 6'(h_w - 5'd1);
        if (code_word == 16'd0) begin
          plan.kind = KIND_ERROR;
        end else if (code_word == 16'd1) begin
          plan.kind = KIND_NONE;
        end else begin
          plan.kind = KIND_BITS;
        end
      end
      default: begin
        plan.kind = KIND_ERROR;
      end
    endcase
  end

endmodule

[hdl/ebp_shifter.sv]
`timescale 1ns / 1ps

module ebp_shifter import ebp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  logic  step,
  input  plan_t plan,
  output logic  bit_o,
  output logic  last_o
);

  logic [3:0]  zeros_left_r, zeros_left_nxt;
  logic [3:0]  g_left_r, g_left_nxt;
  logic [8:0]  g_sr_r, g_sr_nxt;
  logic [5:0]  v_left_r, v_left_nxt;
  logic [31:0] v_sr_r, v_sr_nxt;
  logic [6:0]  total;

  always_comb begin
    total = {3'b0, zeros_left_r} + {3'b0, g_left_r} + {1'b0, v_left_r};
    last_o = (total == 7'd1);
    if (zeros_left_r != 4'd0) begin
      bit_o = 1'b0;
    end else if (g_left_r != 4'd0) begin
      bit_o = g_sr_r[8];
    end else begin
      bit_o = v_sr_r[31];
    end

    zeros_left_nxt = zeros_left_r;
    g_left_nxt     = g_left_r;
    g_sr_nxt       = g_sr_r;
    v_left_nxt     = v_left_r;
    v_sr_nxt       = v_sr_r;
    if (load) begin
      // left-align both codes so the next bit is always the top bit
      zeros_left_nxt = plan.zeros;
      g_left_nxt     = plan.g_len;
      g_sr_nxt       = 9'(plan.g << (4'd9 - plan.g_len));
      v_left_nxt     = plan.v_len;
      v_sr_nxt       = 32'(plan.v << (6'd32 - plan.v_len));
    end else if (step) begin
      if (zeros_left_r != 4'd0) begin
        zeros_left_nxt = zeros_left_r - 4'd1;
      end else if (g_left_r != 4'd0) begin
        g_left_nxt = g_left_r - 4'd1;
        g_sr_nxt   = {g_sr_r[7:0], 1'b0};
      end else if (v_left_r != 6'd0) begin
        v_left_nxt = v_left_r - 6'd1;
        v_sr_nxt   = {v_sr_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zeros_left_r <= '0;
      g_left_r     <= '0;
      v_left_r     <= '0;
    end else begin
      zeros_left_r <= zeros_left_nxt;
      g_left_r     <= g_left_nxt;
      v_left_r     <= v_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_sr_r <= g_sr_nxt;
    v_sr_r <= v_sr_nxt;
  end

endmodule

[hdl/elias_gamma_bit_packer_top.sv]
`timescale 1ns / 1ps

// Bit packer for a compressor's output stream.
// Input channel (in_*): one operation per word: raw bits, aligned byte, Elias gamma,
// hybrid gamma plus fixed low bits, or a Huffman code word with its marker bit.
// Output channel (out_*): one word per buffer byte written, carrying the byte's index
// and its current value; out_last marks the final write of an operation and
// out_error flags an operation that was rejected and left the state unchanged.
// An operation is registered when taken and decoded in the cycle after. Aligned bytes
// and rejected operations then produce their single word; coded operations place one
// bit per cycle, while the output register is free, through a shift register, each
// item carrying 1 to 41 coded bits. A new item is taken once the previous one has
// placed its last bit; a finished word waiting in the output register does not
// block that.
// A stalled receiver holds the output register and freezes the shifter until the
// word is taken. Reset clears the bit position, the open byte and the free index,
// and empties the output register.

module elias_gamma_bit_packer_top import ebp_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_bit_count,
  input  logic [15:0] in_code_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_byte_index,
  output logic [7:0]  out_byte_data,
  output logic        out_last,
  output logic        out_error
);

  state_t state_r, state_nxt;

  logic [2:0]  item_opcode_r;
  logic [31:0] item_value_r;
  logic [5:0]  item_bit_count_r;
  logic [15:0] item_code_word_r;

  logic [2:0]            bit_pos_r, bit_pos_nxt;
  logic [INDEX_BITS-1:0] build_index_r, build_index_nxt;
  logic [7:0]            build_byte_r, build_byte_nxt;
  logic [INDEX_BITS-1:0] next_free_r, next_free_nxt;
  logic [2:0]            res_cnt_r, res_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_byte_index_r, out_byte_index_nxt;
  logic [7:0]  out_byte_data_r, out_byte_data_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_error_r, out_error_nxt;

  plan_t                 plan;
  logic                  accept;
  logic                  out_free;
  logic                  sh_load;
  logic                  sh_step;
  logic                  sh_bit;
  logic                  sh_last;
  logic [INDEX_BITS-1:0] cur_idx;
  logic [7:0]            byte_new;

  ebp_decode u_decode (
    .opcode    (item_opcode_r),
    .value     (item_value_r),
    .bit_count (item_bit_count_r),
    .code_word (item_code_word_r),
    .plan      (plan)
  );

  ebp_shifter u_shifter (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (sh_load),
    .step   (sh_step),
    .plan   (plan),
    .bit_o  (sh_bit),
    .last_o (sh_last)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (plan.kind == KIND_BITS) begin
          state_nxt = ST_SHIFT;
        end else if (plan.kind == KIND_NONE || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (out_free && sh_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;
    sh_load  = (state_r == ST_DECODE) && (plan.kind == KIND_BITS);
    sh_step  = (state_r == ST_SHIFT) && out_free;

    if (bit_pos_r == 3'd0) begin
      cur_idx  = next_free_r;
      byte_new = 8'(sh_bit);
    end else begin
      cur_idx  = build_index_r;
      byte_new = build_byte_r | (8'(sh_bit) << bit_pos_r);
    end

    bit_pos_nxt     = bit_pos_r;
    build_index_nxt = build_index_r;
    build_byte_nxt  = build_byte_r;
    next_free_nxt   = next_free_r;
    res_cnt_nxt     = res_cnt_r;

    out_valid_nxt      = out_valid_r && !out_ready;
    out_byte_index_nxt = out_byte_index_r;
    out_byte_data_nxt  = out_byte_data_r;
    out_last_nxt       = out_last_r;
    out_error_nxt      = out_error_r;

    if (sh_load) begin
      res_cnt_nxt = '0;
    end

    if (state_r == ST_DECODE && out_free) begin
      if (plan.kind == KIND_ERROR) begin
        out_valid_nxt      = 1'b1;
        out_byte_index_nxt = '0;
        out_byte_data_nxt  = '0;
        out_last_nxt       = 1'b1;
        out_error_nxt      = 1'b1;
      end else if (plan.kind == KIND_BYTE) begin
        out_valid_nxt      = 1'b1;
        out_byte_index_nxt = 16'(next_free_r);
        out_byte_data_nxt  = plan.v[7:0];
        out_last_nxt       = 1'b1;
        out_error_nxt      = 1'b0;
        next_free_nxt      = next_free_r + INDEX_BITS'(1);
      end
    end

    if (sh_step) begin
      bit_pos_nxt     = bit_pos_r + 3'd1;
      build_index_nxt = cur_idx;
      build_byte_nxt  = byte_new;
      if (bit_pos_r == 3'd0) begin
        next_free_nxt = next_free_r + INDEX_BITS'(1);
      end
      // drop writes past the per-item limit
      if ((bit_pos_r == BIT_LAST || sh_last) && res_cnt_r < 3'(MAX_OUT)) begin
        out_valid_nxt      = 1'b1;
        out_byte_index_nxt = 16'(cur_idx);
        out_byte_data_nxt  = byte_new;
        out_last_nxt       = sh_last || (res_cnt_r == 3'(MAX_OUT - 1));
        out_error_nxt      = 1'b0;
        res_cnt_nxt        = res_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      bit_pos_r     <= '0;
      build_index_r <= '0;
      build_byte_r  <= '0;
      next_free_r   <= '0;
      res_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      bit_pos_r     <= bit_pos_nxt;
      build_index_r <= build_index_nxt;
      build_byte_r  <= build_byte_nxt;
      next_free_r   <= next_free_nxt;
      res_cnt_r     <= res_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_opcode_r    <= in_opcode;
      item_value_r     <= in_value;
      item_bit_count_r <= in_bit_count;
      item_code_word_r <= in_code_word;
    end
    out_byte_index_r <= out_byte_index_nxt;
    out_byte_data_r  <= out_byte_data_nxt;
    out_last_r       <= out_last_nxt;
    out_error_r      <= out_error_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte_index = out_byte_index_r;
  assign out_byte_data  = out_byte_data_r;
  assign out_last       = out_last_r;
  assign out_error      = out_error_r;

endmodule

[hdl/ebp_checker.sv]
`timescale 1ns / 1ps

module ebp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_opcode,
  input logic [31:0] in_value,
  input logic [5:0]  in_bit_count,
  input logic [15:0] in_code_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_byte_index,
  input logic [7:0]  out_byte_data,
  input logic        out_last,
  input logic        out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_index) &&
      $stable(out_byte_data) && $stable(out_last) && $stable(out_error))
    else $error("output word changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode) && $stable(in_value) &&
      $stable(in_bit_count) && $stable(in_code_word))
    else $error("input word changed while waiting");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && out_byte_index == 16'd0 &&
      out_byte_data == 8'd0)
    else $error("error word is not a lone zero write");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left output valid or input blocked");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken before decode");

endmodule

bind elias_gamma_bit_packer_top ebp_checker u_ebp_checker (.*);

[dv/tb_elias_gamma_bit_packer_top.sv]
`timescale 1ns / 1ps

module tb_elias_gamma_bit_packer_top;
  import ebp_pkg::*;

  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM = 300;

  typedef struct packed {
    logic [15:0] idx;
    logic [7:0]  data;
    logic        last;
    logic        err;
  } write_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [5:0]  count;
    logic [15:0] code;
    logic        typed;
    write_t      typed_write;
  } stim_row_t;

  localparam write_t REJECT = '{16'h0000, 8'h00, 1'b1, 1'b1};
  localparam write_t NONE = '{16'h0000, 8'h00, 1'b0, 1'b0};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [31:0] in_value;
  logic [5:0]  in_bit_count;
  logic [15:0] in_code_word;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_byte_index;
  logic [7:0]  out_byte_data;
  logic        out_last;
  logic        out_error;

  elias_gamma_bit_packer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .in_bit_count   (in_bit_count),
    .in_code_word   (in_code_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_index (out_byte_index),
    .out_byte_data  (out_byte_data),
    .out_last       (out_last),
    .out_error      (out_error)
  );

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{OP_BYTE,   32'h0000_00A5, 6'd0,  16'h0000, 1'b1, '{16'h0000, 8'hA5, 1'b1, 1'b0}},
    '{OP_RAW,    32'hFFFF_FFFF, 6'd32, 16'h0000, 1'b0, NONE},
    '{OP_RAW,    32'h0000_0000, 6'd0,  16'h0000, 1'b0, NONE},
    '{OP_RAW,    32'h0000_0005, 6'd3,  16'h0000, 1'b0, NONE},
    '{OP_RAW,    32'h1234_5678, 6'd33, 16'h0000, 1'b1, REJECT},
    '{OP_RAW,    32'h0000_0000, 6'd63, 16'h0000, 1'b1, REJECT},
    '{OP_GAMMA,  32'h0000_0001, 6'd0,  16'h0000, 1'b0, NONE},
    '{OP_GAMMA,  32'h0000_0100, 6'd0,  16'h0000, 1'b0, NONE},
    '{OP_GAMMA,  32'h0000_0000, 6'd0,  16'h0000, 1'b1, REJECT},
    '{OP_GAMMA,  32'h0000_0101, 6'd0,  16'h0000, 1'b1, REJECT},
    '{OP_GAMMA,  32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1, REJECT},
    '{OP_HYBRID, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, NONE},
    '{OP_HYBRID, 32'hFFFF_FFFF, 6'd32, 16'h0000, 1'b0, NONE},
    '{OP_HYBRID, 32'hFFAB_CDEF, 6'd24, 16'h0000, 1'b0, NONE},
    '{OP_HYBRID, 32'h0000_0100, 6'd0,  16'h0000, 1'b1, REJECT},
    '{OP_HYBRID, 32'h0000_0000, 6'd33, 16'h0000, 1'b1, REJECT},
    '{OP_HUFF,   32'h0000_0000, 6'd0,  16'h0001, 1'b0, NONE},
    '{OP_HUFF,   32'h0000_0000, 6'd0,  16'h0000, 1'b1, REJECT},
    '{OP_HUFF,   32'hDEAD_BEEF, 6'd0,  16'hFFFF, 1'b0, NONE},
    '{OP_HUFF,   32'h0000_0000, 6'd0,  16'h8000, 1'b0, NONE},
    '{OP_BYTE,   32'hFFFF_FF00, 6'd0,  16'h0000, 1'b0, NONE},
    '{OP_RSVD_5, 32'h0000_0001, 6'd1,  16'h0001, 1'b1, REJECT},
    '{OP_RSVD_6, 32'h0000_0001, 6'd1,  16'h0001, 1'b1, REJECT},
    '{OP_RSVD_7, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, REJECT}
  };

  logic [2:0]  pk_bitpos = '0;
  logic [15:0] pk_build_idx = '0;
  logic [7:0]  pk_build_byte = '0;
  logic [15:0] pk_next_free = '0;
  bit          pk_touched;

  write_t item_writes [$];
  write_t pending_writes [$];
  int     mismatches = 0;
  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;
  int     rx_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int bit_width(logic [31:0] v);
    int w;
    w = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        w = i + 1;
      end
    end
    return w;
  endfunction

  function void note_write(logic [15:0] idx, logic [7:0] data);
    write_t w;
    w = '{idx, data, 1'b0, 1'b0};
    item_writes.push_back(w);
  endfunction

  function void place_bit(logic b);
    if (pk_bitpos == 3'd0) begin
      pk_build_idx = pk_next_free;
      pk_next_free = pk_next_free + 16'd1;
      pk_build_byte = '0;
    end
    if (b) begin
      pk_build_byte[pk_bitpos] = 1'b1;
    end
    pk_touched = 1'b1;
    pk_bitpos = pk_bitpos + 3'd1;
    if (pk_bitpos == 3'd0) begin
      note_write(pk_build_idx, pk_build_byte);
      pk_touched = 1'b0;
    end
  endfunction

  function void place_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) begin
      place_bit(v[i]);
    end
  endfunction

  function void place_gamma(logic [31:0] v);
    int w;
    w = bit_width(v);
    place_bits(32'd0, w - 1);
    place_bits(v, w);
  endfunction

  function void pack_word(logic [2:0] op, logic [31:0] value, logic [5:0] count,
                          logic [15:0] code);
    logic        bad;
    logic [31:0] hi;
    item_writes.delete();
    pk_touched = 1'b0;
    bad = 1'b0;
    hi = '0;
    case (op)
      OP_RAW:   bad = count > 6'd32;
      OP_BYTE:  bad = 1'b0;
      OP_GAMMA: bad = value == 32'd0 || value > GAMMA_LIMIT;
      OP_HYBRID: begin
        if (count > MAX_FIXED_BITS) begin
          bad = 1'b1;
        end else begin
          hi = (count >= 6'd32) ? 32'd0 : (value >> count);
          bad = hi >= GAMMA_LIMIT;
        end
      end
      OP_HUFF:  bad = code == 16'd0;
      default:  bad = 1'b1;
    endcase
    if (bad) begin
      item_writes.push_back(REJECT);
      return;
    end
    case (op)
      OP_RAW:  place_bits(value, int'(count));
      OP_BYTE: begin
        note_write(pk_next_free, value[7:0]);
        pk_next_free = pk_next_free + 16'd1;
      end
      OP_GAMMA: place_gamma(value);
      OP_HYBRID: begin
        place_gamma(hi + 32'd1);
        place_bits(value, int'(count));
      end
      default: place_bits({16'd0, code}, bit_width({16'd0, code}) - 1);
    endcase
    if (pk_touched) begin
      note_write(pk_build_idx, pk_build_byte);
    end
    if (item_writes.size() > 0) begin
      item_writes[item_writes.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic stim_row_t random_word();
    stim_row_t   row;
    int          r;
    int          cnt;
    logic [31:0] hi;
    logic [31:0] hi_max;
    logic [31:0] low;
    row = '{OP_RAW, $urandom, 6'($urandom_range(1, 32)), 16'($urandom), 1'b0, NONE};
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 5))
        0: row.count = 6'($urandom_range(33, 63));
        1: begin
          row.op = OP_GAMMA;
          row.value = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h0000_0200);
        end
        2: begin
          row.op = OP_HYBRID;
          row.count = 6'($urandom_range(0, 63));
        end
        3: begin
          row.op = OP_HUFF;
          row.code = 16'd0;
        end
        4: row.op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        default: begin
          row.op = $urandom_range(0, 1) ? OP_RAW : OP_HUFF;
          row.count = 6'd0;
          row.code = 16'd1;
        end
      endcase
    end else if (r < 35) begin
      row.op = OP_RAW;
    end else if (r < 50) begin
      row.op = OP_BYTE;
    end else if (r < 65) begin
      row.op = OP_GAMMA;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: row.value = 32'd1;
          1: row.value = 32'd2;
          2: row.value = 32'd255;
          default: row.value = 32'd256;
        endcase
      end else begin
        row.value = $urandom_range(1, 256);
      end
    end else if (r < 85) begin
      row.op = OP_HYBRID;
      cnt = $urandom_range(0, 32);
      if (cnt >= 32) begin
        hi_max = 32'd0;
      end else if (cnt > 24) begin
        hi_max = (32'd1 << (32 - cnt)) - 32'd1;
      end else begin
        hi_max = 32'd255;
      end
      hi = $urandom_range(0, 3) == 0 ? hi_max : $urandom_range(0, hi_max);
      low = (cnt == 0) ? 32'd0 : ($urandom & (32'hFFFF_FFFF >> (32 - cnt)));
      row.count = 6'(cnt);
      row.value = (cnt >= 32) ? $urandom : ((hi << cnt) | low);
    end else begin
      row.op = OP_HUFF;
      cnt = $urandom_range(1, 15);
      row.code = 16'((32'd1 << cnt) | ($urandom & ((32'd1 << cnt) - 32'd1)));
    end
    return row;
  endfunction

  task automatic send_word(input stim_row_t row);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= row.op;
    in_value     <= row.value;
    in_bit_count <= row.count;
    in_code_word <= row.code;
    do @(posedge clk); while (!in_ready);
    pack_word(row.op, row.value, row.count, row.code);
    if (row.typed) begin
      item_writes.delete();
      item_writes.push_back(row.typed_write);
    end
    foreach (item_writes[i]) begin
      pending_writes.push_back(item_writes[i]);
    end
    @(negedge clk);
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
        rx_hold = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    write_t want;
    write_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte_index, out_byte_data, out_last, out_error};
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected write: idx %h data %h last %b err %b",
                   got.idx, got.data, got.last, got.err);
        end
      end else begin
        want = pending_writes.pop_front();
        if (got.idx !== want.idx || got.data !== want.data ||
            got.last !== want.last || got.err !== want.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp %h/%h/%b/%b got %h/%h/%b/%b",
                     want.idx, want.data, want.last, want.err,
                     got.idx, got.data, got.last, got.err);
          end
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = OP_RAW;
    in_value     = '0;
    in_bit_count = '0;
    in_code_word = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i]);
    end
    drain_writes();

    for (int n = 0; n < N_RANDOM; n++) begin
      tx_steady = (n / 60) % 3 == 2;
      rx_steady = tx_steady;
      if ($urandom_range(0, 49) == 0) begin
        drain_writes();
      end
      send_word(random_word());
    end
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ebp_pkg.sv
hdl/ebp_decode.sv
hdl/ebp_shifter.sv
hdl/elias_gamma_bit_packer_top.sv
hdl/ebp_checker.sv
dv/tb_elias_gamma_bit_packer_top.sv
